[sv/sbs_pkg.sv]
// Shared types and constants for the safety brake supervisor.
`default_nettype none
package sbs_pkg;

  // Event kinds (input tuser)
  localparam logic [2:0] KIND_TICK        = 3'd0;
  localparam logic [2:0] KIND_ESTOP_SET   = 3'd1;
  localparam logic [2:0] KIND_ESTOP_CLR   = 3'd2;
  localparam logic [2:0] KIND_FAULT_SET   = 3'd3;
  localparam logic [2:0] KIND_FAULT_CLR   = 3'd4;
  localparam logic [2:0] KIND_MODE_SET    = 3'd5;

  // Control modes
  localparam logic [1:0] MODE_STANDBY     = 2'd0;
  localparam logic [1:0] MODE_RC          = 2'd1;
  localparam logic [1:0] MODE_EXTERNAL    = 2'd2;
  localparam logic [1:0] MODE_BRAKE       = 2'd3;

  // Brake actions
  localparam logic [1:0] ACT_NONE         = 2'd0;
  localparam logic [1:0] ACT_APPLY        = 2'd1;
  localparam logic [1:0] ACT_RELEASE      = 2'd2;

  // Remote mode request codes
  localparam logic [7:0] REQ_RC           = 8'd1;
  localparam logic [7:0] REQ_OFFBOARD     = 8'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_RECOVERY_MS  = 2'd0;
  localparam logic [1:0] CFG_LINK_BIT     = 2'd1;
  localparam logic [1:0] CFG_IMU_BIT      = 2'd2;

  localparam logic [31:0] RECOVERY_MS_RST = 32'd500;
  localparam logic [4:0]  LINK_BIT_RST    = 5'd0;
  localparam logic [4:0]  IMU_BIT_RST     = 5'd1;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic [31:0] recovery_time_ms;
    logic [4:0]  link_fault_bit;
    logic [4:0]  imu_fault_bit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] fault_mask;
    logic [1:0]  new_mode;
    logic        link_ok;
    logic        imu_ok;
    logic        remote_valid;
    logic        remote_estop;
    logic [7:0]  remote_mode;
    logic [31:0] now_ms;
  } item_t;

  // Supervisor state apart from the fault word
  typedef struct packed {
    logic        estop;
    logic [1:0]  mode;
    logic [31:0] recovery_start;
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  brake_action;
    logic        mode_published;
    logic        estop_active;
    logic [31:0] fault_word;
    logic [31:0] faults_newly_set;
    logic [31:0] faults_newly_cleared;
  } result_t;

endpackage
`default_nettype wire

[sv/sbs_cfg.sv]
// Configuration register bank for the safety brake supervisor.
`default_nettype none
module sbs_cfg
  import sbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.recovery_time_ms <= RECOVERY_MS_RST;
      cfg_r.link_fault_bit   <= LINK_BIT_RST;
      cfg_r.imu_fault_bit    <= IMU_BIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RECOVERY_MS: cfg_r.recovery_time_ms <= cfg_data;
        CFG_LINK_BIT:    cfg_r.link_fault_bit   <= cfg_data[4:0];
        CFG_IMU_BIT:     cfg_r.imu_fault_bit    <= cfg_data[4:0];
        default:         ;  // unused index, write dropped
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/sbs_in_reg.sv]
// Input register stage: captures one event word and unpacks it.
`default_nettype none
module sbs_in_reg
  import sbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [2:0]           in_tuser,
  input  wire logic                 advance,
  output logic                      item_valid,
  output item_t                     item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.kind         = in_tuser;
    item_nxt.fault_mask   = in_tdata[31:0];
    item_nxt.new_mode     = in_tdata[33:32];
    item_nxt.link_ok      = in_tdata[34];
    item_nxt.imu_ok       = in_tdata[35];
    item_nxt.remote_valid = in_tdata[36];
    item_nxt.remote_estop = in_tdata[37];
    item_nxt.remote_mode  = in_tdata[45:38];
    item_nxt.now_ms       = in_tdata[77:46];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/sbs_step.sv]
// Next-state and result logic for one supervisor event.
`default_nettype none
module sbs_step
  import sbs_pkg::*;
#(
  parameter int FAULT_WIDTH = 32
) (
  input  wire item_t                    item,
  input  wire cfg_t                     cfg,
  input  wire state_t                   state,
  input  wire logic [FAULT_WIDTH-1:0]   fault,
  output state_t                        state_nxt,
  output logic      [FAULT_WIDTH-1:0]   fault_nxt,
  output result_t                       result
);

  logic [63:0]            lm_full, im_full, fm_full;
  logic [63:0]            f_ext, set_ext, clr_ext;
  logic [FAULT_WIDTH-1:0] lm, im, fm;
  logic [FAULT_WIDTH-1:0] f, acc_set, acc_clr;
  logic [31:0]            elapsed;
  logic [1:0]             action;
  logic                   published;

  // Bit masks beyond FAULT_WIDTH fall off the top and become zero
  assign lm_full = 64'd1 << cfg.link_fault_bit;
  assign im_full = 64'd1 << cfg.imu_fault_bit;
  assign fm_full = {32'd0, item.fault_mask};
  assign lm      = lm_full[FAULT_WIDTH-1:0];
  assign im      = im_full[FAULT_WIDTH-1:0];
  assign fm      = fm_full[FAULT_WIDTH-1:0];
  assign elapsed = item.now_ms - state.recovery_start;

  always_comb begin
    state_nxt = state;
    f         = fault;
    acc_set   = '0;
    acc_clr   = '0;
    action    = ACT_NONE;
    published = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        // link first, then IMU; both may hit the same bit
        if (!item.link_ok) begin
          if ((f & lm) == '0) begin
            f       = f | lm;
            acc_set = acc_set | lm;
          end
        end else if ((f & lm) != '0) begin
          f       = f & ~lm;
          acc_clr = acc_clr | lm;
        end
        if (!item.imu_ok) begin
          if ((f & im) == '0) begin
            f       = f | im;
            acc_set = acc_set | im;
          end
        end else if ((f & im) != '0) begin
          f       = f & ~im;
          acc_clr = acc_clr | im;
        end
        if (item.remote_valid && item.remote_estop) begin
          state_nxt.estop = 1'b1;
        end
        if (state_nxt.estop || ((f & (lm | im)) != '0)) begin
          state_nxt.mode           = MODE_BRAKE;
          state_nxt.recovery_start = '0;
          action                   = ACT_APPLY;
          published                = 1'b1;
        end else if (state.recovery_start == '0) begin
          state_nxt.recovery_start = item.now_ms;
        end else if (elapsed >= cfg.recovery_time_ms) begin
          if (item.remote_valid && item.remote_mode == REQ_RC) begin
            state_nxt.mode = MODE_RC;
          end else if (item.remote_valid && item.remote_mode == REQ_OFFBOARD) begin
            state_nxt.mode = MODE_EXTERNAL;
          end else begin
            state_nxt.mode = MODE_STANDBY;
          end
          action    = ACT_RELEASE;
          published = 1'b1;
        end
      end
      KIND_ESTOP_SET: begin
        state_nxt.estop = 1'b1;
        state_nxt.mode  = MODE_BRAKE;
        action          = ACT_APPLY;
      end
      KIND_ESTOP_CLR: begin
        state_nxt.estop = 1'b0;
      end
      KIND_FAULT_SET: begin
        if ((f & fm) == '0) begin
          f       = f | fm;
          acc_set = fm;
        end
      end
      KIND_FAULT_CLR: begin
        if ((f & fm) != '0) begin
          f       = f & ~fm;
          acc_clr = fm;
        end
      end
      KIND_MODE_SET: begin
        state_nxt.mode = item.new_mode;
      end
      default: ;
    endcase
  end

  assign fault_nxt = f;
  assign f_ext     = 64'(f);
  assign set_ext   = 64'(acc_set);
  assign clr_ext   = 64'(acc_clr);

  always_comb begin
    result.mode                 = state_nxt.mode;
    result.brake_action         = action;
    result.mode_published       = published;
    result.estop_active         = state_nxt.estop;
    result.fault_word           = f_ext[31:0];
    result.faults_newly_set     = set_ext[31:0];
    result.faults_newly_cleared = clr_ext[31:0];
  end

endmodule
`default_nettype wire

[sv/safety_brake_supervisor_top.sv]
// Top level of the safety brake supervisor: state, result register, ports.
//
// Usage:
//   Input stream (in_*): one event word per handshake. in_tuser carries the
//   event kind (tick, e-stop trigger/clear, fault set/clear, forced mode);
//   in_tdata carries the event payload. Every accepted word yields exactly
//   one result word on the out_* stream, in order.
//   Config channel (cfg_*): register index plus data, always ready. Write
//   only while no event is in flight. Index 3 is ignored.
//   A word accepted into the input register is evaluated against the current
//   state and lands in the result register, which drives out_tvalid.
//   Throughput: one word per cycle unless out_tready stalls. The state update
//   (fault word, e-stop latch, mode, recovery start) completes in the same
//   cycle as the result capture, so the next word always sees the state left
//   by the previous one.
//   The critical path is the 32-bit recovery time subtract and compare.
//   Reset (rst_n low, synchronous): both stages empty, e-stop clear, faults
//   clear, mode idle, recovery not started, config back to defaults.
//   Stall: while out_tready is low the result word holds; one more input
//   word is taken into the input register, then in_tready drops until the
//   receiver drains the result.
`default_nettype none
module safety_brake_supervisor_top
  import sbs_pkg::*;
#(
  parameter int FAULT_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // [31:0] fault_mask, [33:32] new_mode, [34] link_ok, [35] imu_ok,
  // [36] remote_valid, [37] remote_estop, [45:38] remote_mode,
  // [77:46] now_ms, [79:78] unused
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [2:0]            in_tuser,   // [2:0] kind
  // [1:0] mode, [3:2] brake_action, [4] mode_published, [5] estop_active,
  // [37:6] fault_word, [69:38] faults_newly_set,
  // [101:70] faults_newly_cleared, [103:102] zero
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);

  cfg_t                   cfg;
  item_t                  item;
  logic                   item_valid;
  logic                   advance;

  state_t                 state_r, state_nxt;
  logic [FAULT_WIDTH-1:0] fault_r, fault_nxt;
  result_t                res_nxt, out_r;
  logic                   out_valid_r;

  // Move the held word into the result register when it is free or draining
  assign advance = item_valid && (!out_valid_r || out_tready);

  sbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sbs_step #(
    .FAULT_WIDTH (FAULT_WIDTH)
  ) u_step (
    .item      (item),
    .cfg       (cfg),
    .state     (state_r),
    .fault     (fault_r),
    .state_nxt (state_nxt),
    .fault_nxt (fault_nxt),
    .result    (res_nxt)
  );

  // Supervisor state, committed together with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.estop          <= 1'b0;
      state_r.mode           <= MODE_STANDBY;
      state_r.recovery_start <= '0;
      fault_r                <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      fault_r <= fault_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_r.faults_newly_cleared,
                       out_r.faults_newly_set,
                       out_r.fault_word,
                       out_r.estop_active,
                       out_r.mode_published,
                       out_r.brake_action,
                       out_r.mode};

`ifndef ASSERT_OFF
  // Applying the brake always goes with brake mode
  a_apply_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.brake_action == ACT_APPLY |-> out_r.mode == MODE_BRAKE)
    else $error("apply brake without brake mode");

  // A release only happens with e-stop clear and is always announced
  a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.brake_action == ACT_RELEASE
      |-> !out_r.estop_active && out_r.mode_published && out_r.mode != MODE_BRAKE)
    else $error("release with e-stop set or unannounced");

  // State only moves when a word is committed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r) && $stable(fault_r))
    else $error("state changed without a committed word");

  // Full pipe with a stalled receiver must back-pressure the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while both stages are blocked");
`endif

endmodule
`default_nettype wire
